/* hdl/b64enc_pkg.sv */
// Shared types, constants and the character mapping for the Base64 stream encoder.
// Used by every module in hdl; depends on nothing else.
package b64enc_pkg;

	typedef enum logic [1:0] {
		MODE_STD  = 2'd0,
		MODE_URL  = 2'd1,
		MODE_IMAP = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2,
		PH_3 = 2'd3
	} phase_t;

	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_UNDER = 8'h5F;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam logic [5:0] IDX_LC_BASE  = 6'd26;
	localparam logic [5:0] IDX_DIG_BASE = 6'd52;
	localparam logic [5:0] IDX_62       = 6'd62;
	localparam logic [5:0] IDX_63       = 6'd63;

	// One classified input byte: up to four output characters.
	typedef struct packed {
		logic            last;    // final character of the job ends the message
		logic [1:0]      cnt_m1;  // number of characters minus one
		logic [3:0]      pad;     // slot is a pad character
		logic [3:0][5:0] idx;     // alphabet index per slot
	} job_t;

	function automatic logic [7:0] encode_index(input logic [5:0] idx, input mode_t mode);
		logic [7:0] ch;
		if (idx < IDX_LC_BASE) begin
			ch = CHAR_UC_A + {2'b00, idx};
		end else if (idx < IDX_DIG_BASE) begin
			ch = CHAR_LC_A + {2'b00, idx - IDX_LC_BASE};
		end else if (idx < IDX_62) begin
			ch = CHAR_ZERO + {2'b00, idx - IDX_DIG_BASE};
		end else if (idx == IDX_62) begin
			ch = (mode == MODE_URL) ? CHAR_DASH : CHAR_PLUS;
		end else begin
			unique case (mode)
				MODE_STD: ch = CHAR_SLASH;
				MODE_URL: ch = CHAR_UNDER;
				default:  ch = CHAR_COMMA;
			endcase
		end
		return ch;
	endfunction

endpackage

/* hdl/base64_stream_encoder.sv */
// Base64 stream encoder: one raw byte goes in per beat and ASCII Base64 characters come
// out one per beat, in order. A byte in triplet position 0 or 1 yields one character, a
// byte in position 2 yields two, and the last byte of a message flushes the partial
// character and its '=' padding, so a final byte yields up to four. The input side takes
// a byte every cycle while the two-entry job queue has room; the output register delivers
// at most one character per cycle and holds each character until it is popped. The first
// character of a byte passes through the job queue, the back end's job register and the
// output register. The alphabet register is taken on any cfg beat and should only change
// while the encoder is idle.
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_char,
	output logic       last_char,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	b64enc_pkg::mode_t mode_q;
	b64enc_pkg::job_t  wr_job;
	b64enc_pkg::job_t  rd_job;
	logic              job_wr;
	logic              q_full;
	logic              q_empty;
	logic              q_rd;
	logic              in_beat;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_beat   = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= b64enc_pkg::MODE_STD;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= b64enc_pkg::mode_t'(cfg_data);
		end
	end

	b64enc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_beat),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job_wr    (job_wr),
		.job       (wr_job)
	);

	b64enc_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_job (wr_job),
		.full   (q_full),
		.rd_en  (q_rd),
		.rd_job (rd_job),
		.empty  (q_empty)
	);

	b64enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.q_empty   (q_empty),
		.q_job     (rd_job),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

/* hdl/b64enc_front.sv */
// Front end: takes raw bytes, tracks the triplet phase and carry bits, and
// classifies each byte into a job of up to four character slots. Uses b64enc_pkg.
module b64enc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                job_wr,
	output b64enc_pkg::job_t    job
);

	b64enc_pkg::phase_t phase_q;
	logic [5:0]         left_q;
	b64enc_pkg::phase_t phase_nxt;
	logic [5:0]         left_nxt;

	always_comb begin
		job       = '0;
		job.last  = last_byte;
		phase_nxt = phase_q;
		left_nxt  = left_q;
		unique case (phase_q)
			b64enc_pkg::PH_1: begin
				job.idx[0] = left_q | {2'b00, data_byte[7:4]};
				left_nxt   = {data_byte[3:0], 2'b00};
				phase_nxt  = b64enc_pkg::PH_2;
				if (last_byte) begin
					job.idx[1] = left_nxt;
					job.pad[2] = 1'b1;
					job.cnt_m1 = 2'd2;
				end
			end
			b64enc_pkg::PH_2: begin
				job.idx[0] = left_q | {4'b0000, data_byte[7:6]};
				job.idx[1] = data_byte[5:0];
				job.cnt_m1 = 2'd1;
				left_nxt   = '0;
				phase_nxt  = b64enc_pkg::PH_0;
			end
			default: begin
				job.idx[0] = data_byte[7:2];
				left_nxt   = {data_byte[1:0], 4'b0000};
				phase_nxt  = b64enc_pkg::PH_1;
				if (last_byte) begin
					job.idx[1] = left_nxt;
					job.pad[2] = 1'b1;
					job.pad[3] = 1'b1;
					job.cnt_m1 = 2'd3;
				end
			end
		endcase
		if (last_byte) begin
			phase_nxt = b64enc_pkg::PH_0;
			left_nxt  = '0;
		end
	end

	assign job_wr = in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64enc_pkg::PH_0;
			left_q  <= '0;
		end else if (in_valid) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

/* hdl/b64enc_job_q.sv */
// Two-entry queue of classified jobs between the front and back ends.
// Uses b64enc_pkg for the job record.
module b64enc_job_q (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  b64enc_pkg::job_t wr_job,
	output logic             full,
	input  logic             rd_en,
	output b64enc_pkg::job_t rd_job,
	output logic             empty
);

	localparam int Depth = 2;

	b64enc_pkg::job_t mem_q [Depth];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full   = (count_q == 2'(Depth));
	assign empty  = (count_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* hdl/b64enc_back.sv */
// Back end: walks the slots of each job, maps indexes to ASCII through the
// selected alphabet and holds one character in the output register. Uses b64enc_pkg.
module b64enc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64enc_pkg::mode_t mode,
	input  logic             q_empty,
	input  b64enc_pkg::job_t q_job,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_char,
	output logic             last_char
);

	b64enc_pkg::job_t job_q;
	logic             job_valid_q;
	logic [1:0]       slot_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic out_taken;
	logic emit;
	logic final_slot;
	logic job_done;
	logic load;

	assign out_taken  = out_valid_q && pop;
	assign emit       = job_valid_q && (!out_valid_q || out_taken);
	assign final_slot = (slot_q == job_q.cnt_m1);
	assign job_done   = emit && final_slot;
	// A queued job loads when none is held or in the same cycle the previous one emits its final slot.
	assign load       = (!job_valid_q || job_done) && !q_empty;
	assign q_rd       = load;

	assign empty     = !out_valid_q;
	assign out_char  = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				job_valid_q <= 1'b1;
				slot_q      <= '0;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				slot_q <= slot_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
		if (emit) begin
			char_q <= job_q.pad[slot_q] ? b64enc_pkg::CHAR_PAD
			                            : b64enc_pkg::encode_index(job_q.idx[slot_q], mode);
			last_q <= job_q.last && final_slot;
		end
	end

endmodule

/* hdl/b64enc_check.sv */
// Port-level checker for the Base64 stream encoder, bound to the top level.
// Depends on b64enc_pkg for character constants.
module b64enc_check (
	input logic       clk,
	input logic       arst_n,
	input logic       pop,
	input logic       empty,
	input logic [7:0] out_char,
	input logic       last_char
);

	logic is_alpha;
	logic is_sym;

	assign is_alpha = (out_char >= 8'h41 && out_char <= 8'h5A)
	               || (out_char >= 8'h61 && out_char <= 8'h7A)
	               || (out_char >= 8'h30 && out_char <= 8'h39);
	assign is_sym   = (out_char == b64enc_pkg::CHAR_PLUS) || (out_char == b64enc_pkg::CHAR_SLASH)
	               || (out_char == b64enc_pkg::CHAR_DASH) || (out_char == b64enc_pkg::CHAR_UNDER)
	               || (out_char == b64enc_pkg::CHAR_COMMA) || (out_char == b64enc_pkg::CHAR_PAD);

	// A waiting character holds until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_char) && $stable(last_char))
		else $error("output character changed while stalled");

	// Only alphabet characters and padding ever appear.
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> is_alpha || is_sym)
		else $error("character outside the Base64 alphabet");

	// A first pad is followed at once by the final pad of the message.
	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && out_char == b64enc_pkg::CHAR_PAD && !last_char
		|=> !empty && out_char == b64enc_pkg::CHAR_PAD && last_char)
		else $error("first pad not followed by final pad");

endmodule

bind base64_stream_encoder b64enc_check u_check (.*);
